// ===== rtl/hst_pkg.sv =====
// Shared types and constants for the hypercomplex soft-threshold block.
// Used by the channel interfaces, the root/divide unit and the top level.
// No dependencies.
package hst_pkg;

   localparam int COEF_W     = 32;
   localparam int LAMBDA_W   = 33;
   localparam int OP_W       = 2;
   localparam int DIMS_W     = 2;
   localparam int NUM_FIELDS = 4;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 65;
   localparam int NORM_W     = 33;
   localparam int RES_W      = 32;
   localparam int ROOT_STEPS = 32;
   localparam int STEP_W     = 5;
   localparam int REM_W      = 35;

   localparam logic [DIMS_W-1:0] ALG_DIMS_RESET = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_SET       = 2'd0,
      OP_MEASURE   = 2'd1,
      OP_THRESHOLD = 2'd2
   } op_type;

   typedef enum logic {
      UNIT_ROOT,
      UNIT_DIV
   } unit_op_type;

   typedef struct packed {
      logic        go;
      unit_op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== rtl/hst_channels.sv =====
// Valid/ready channel interfaces: request, response and control register write.
// Depends on hst_pkg for field widths.
interface hst_req_if;
   logic                              valid;
   logic                              ready;
   logic [hst_pkg::OP_W-1:0]          opcode;
   logic signed [hst_pkg::COEF_W-1:0] coef_0;
   logic signed [hst_pkg::COEF_W-1:0] coef_1;
   logic signed [hst_pkg::COEF_W-1:0] coef_2;
   logic signed [hst_pkg::COEF_W-1:0] coef_3;
   logic [hst_pkg::LAMBDA_W-1:0]      lambda_value;

   modport source (output valid, opcode, coef_0, coef_1, coef_2, coef_3, lambda_value,
                   input ready);
   modport sink (input valid, opcode, coef_0, coef_1, coef_2, coef_3, lambda_value,
                 output ready);
endinterface

interface hst_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hst_pkg::COEF_W-1:0] out_coef_0;
   logic signed [hst_pkg::COEF_W-1:0] out_coef_1;
   logic signed [hst_pkg::COEF_W-1:0] out_coef_2;
   logic signed [hst_pkg::COEF_W-1:0] out_coef_3;
   logic [hst_pkg::LAMBDA_W-1:0]      lambda_now;

   modport source (output valid, out_coef_0, out_coef_1, out_coef_2, out_coef_3, lambda_now,
                   input ready);
   modport sink (input valid, out_coef_0, out_coef_1, out_coef_2, out_coef_3, lambda_now,
                 output ready);
endinterface

interface hst_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hst_pkg::DIMS_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/hst_root_div.sv =====
// Iterative square root / divide unit, one result bit per cycle.
// One shared subtract-and-compare serves both operations. Depends on hst_pkg.
module hst_root_div (
   input  logic                         clock,
   input  logic                         reset,
   input  hst_pkg::unit_cmd_type        cmd,
   input  logic [hst_pkg::PROD_W-1:0]   radicand,
   input  logic [hst_pkg::RES_W-1:0]    dividend,
   input  logic [hst_pkg::NORM_W-1:0]   divisor,
   output hst_pkg::unit_stat_type       stat,
   output logic [hst_pkg::RES_W-1:0]    result
);

   localparam int RW = hst_pkg::REM_W;
   localparam int PW = hst_pkg::PROD_W;
   localparam int QW = hst_pkg::RES_W;
   localparam int SW = hst_pkg::STEP_W;

   logic                 busy_ff;
   logic                 done_ff;
   hst_pkg::unit_op_type op_ff;
   logic [SW-1:0]        step_ff;
   logic [RW-1:0]        rem_ff;
   logic [QW-1:0]        acc_ff;
   logic [PW-1:0]        src_ff;
   logic [hst_pkg::NORM_W-1:0] dvs_ff;

   logic [RW-1:0] opa;
   logic [RW-1:0] opb;
   logic [RW:0]   diff;
   logic          ge;
   logic [RW-1:0] rem_in;

   always_comb begin
      if (op_ff == hst_pkg::UNIT_ROOT) begin
         opa = {rem_ff[RW-3:0], src_ff[PW-1:PW-2]};
         opb = {1'b0, acc_ff, 2'b01};
      end else begin
         opa = {rem_ff[RW-2:0], 1'b0};
         opb = {2'b00, dvs_ff};
      end
      diff   = {1'b0, opa} - {1'b0, opb};
      ge     = ~diff[RW];
      rem_in = ge ? diff[RW-1:0] : opa;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            busy_ff <= 1'b1;
            op_ff   <= cmd.op;
            step_ff <= '0;
            rem_ff  <= (cmd.op == hst_pkg::UNIT_ROOT) ? '0 : {3'b000, dividend};
            acc_ff  <= '0;
            src_ff  <= radicand;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            acc_ff  <= {acc_ff[QW-2:0], ge};
            src_ff  <= {src_ff[PW-3:0], 2'b00};
            step_ff <= step_ff + 1'b1;
            if (step_ff == SW'(hst_pkg::ROOT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

// ===== rtl/hypercomplex_soft_threshold.sv =====
// Soft threshold of 1, 2 or 4 coefficient hypercomplex scalars (Q16.16).
// Set, opcode 3 and measure while disarmed go straight to the response; armed measure and
// threshold form the square sum and its root; threshold above lambda adds a divide and a
// scaling pass on the shared root/divide unit; the root is skipped when the square sum reaches 2^64.
// One request at a time; next request taken the cycle after the result is registered.
// Synchronous active-high reset: lambda 0, search armed, alg_dims 1, output empty.
module hypercomplex_soft_threshold #(
   parameter int MAX_COEFS = 4
) (
   input  logic         clock,
   input  logic         reset,
   hst_csr_if.sink      csr_chan,
   hst_req_if.sink      req_chan,
   hst_rsp_if.source    rsp_chan
);

   localparam int CW  = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
   localparam int DW  = hst_pkg::COEF_W;
   localparam int LW  = hst_pkg::LAMBDA_W;
   localparam int PW  = hst_pkg::PROD_W;
   localparam int SMW = hst_pkg::SUM_W;
   localparam int NW  = hst_pkg::NORM_W;
   localparam int NF  = hst_pkg::NUM_FIELDS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DRAIN,
      S_ROOT_GO,
      S_ROOT,
      S_CMP,
      S_DIV,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [hst_pkg::DIMS_W-1:0] alg_dims_ff;
   logic [LW-1:0]              lambda_ff;
   logic                       armed_ff;
   logic [hst_pkg::OP_W-1:0]   op_ff;
   logic                       scale_ff;
   logic [CW-1:0]              cnt_ff;
   logic [CW-1:0]              pidx_ff;
   logic                       pv_ff;
   logic [DW-1:0]              mag_ff [MAX_COEFS];
   logic                       neg_ff [MAX_COEFS];
   logic [DW-1:0]              q_ff   [MAX_COEFS];
   logic [PW-1:0]              prod_ff;
   logic [SMW-1:0]             sum_ff;
   logic [NW-1:0]              norm_ff;
   logic [NW-1:0]              f_ff;
   hst_pkg::unit_cmd_type      cmd_ff;
   logic                       rsp_valid_ff;
   logic [DW-1:0]              rsp_coef_ff [NF];
   logic [LW-1:0]              rsp_lambda_ff;

   logic [DW-1:0]              req_coef [NF];
   logic [DW-1:0]              q_ext    [NF];
   logic [CW-1:0]              last_idx;
   logic [NW-1:0]              mul_b;
   logic [PW:0]                prod_full;
   logic [PW-1:0]              prod_in;
   logic [SMW-1:0]             sum_in;
   logic [PW-1:0]              rnd;
   logic [DW-1:0]              q_mag;
   logic [DW-1:0]              q_in;
   logic [NW-1:0]              f_in;
   logic                       norm_gt;
   logic                       out_free;
   logic                       accept;
   hst_pkg::unit_stat_type     unit_stat;
   logic [hst_pkg::RES_W-1:0]  unit_result;

   assign req_coef[0] = req_chan.coef_0;
   assign req_coef[1] = req_chan.coef_1;
   assign req_coef[2] = req_chan.coef_2;
   assign req_coef[3] = req_chan.coef_3;

   for (genvar g = 0; g < NF; g++) begin : g_qext
      if (g < MAX_COEFS) begin : g_used
         assign q_ext[g] = q_ff[g];
      end else begin : g_unused
         assign q_ext[g] = '0;
      end
   end

   always_comb begin
      int ncount;
      unique case (alg_dims_ff)
         2'd0:    ncount = 1;
         2'd1:    ncount = 2;
         default: ncount = 4;
      endcase
      if (ncount > MAX_COEFS) begin
         ncount = MAX_COEFS;
      end
      last_idx = CW'(ncount - 1);
   end

   always_comb begin
      mul_b     = scale_ff ? f_ff : {1'b0, mag_ff[cnt_ff]};
      prod_full = (PW+1)'(mag_ff[cnt_ff]) * (PW+1)'(mul_b);
      prod_in   = prod_full[PW-1:0];
      sum_in    = sum_ff + {1'b0, prod_ff};
      rnd       = prod_ff + 64'h0000_0000_8000_0000;
      q_mag     = rnd[PW-1:DW];
      q_in      = neg_ff[pidx_ff] ? (DW'(0) - q_mag) : q_mag;
      f_in      = 33'h1_0000_0000 - {1'b0, unit_result};
      norm_gt   = norm_ff > lambda_ff;
      out_free  = ~rsp_valid_ff | rsp_chan.ready;
      accept    = req_chan.valid & req_chan.ready;
   end

   hst_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_ff),
      .radicand (sum_ff[PW-1:0]),
      .dividend (lambda_ff[hst_pkg::RES_W-1:0]),
      .divisor  (norm_ff),
      .stat     (unit_stat),
      .result   (unit_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alg_dims_ff  <= hst_pkg::ALG_DIMS_RESET;
         lambda_ff    <= '0;
         armed_ff     <= 1'b1;
         pv_ff        <= 1'b0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff.go <= 1'b0;
         if (csr_chan.valid) begin
            alg_dims_ff <= csr_chan.data;
         end
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == S_MUL || state_ff == S_DRAIN) && pv_ff) begin
            if (scale_ff) begin
               q_ff[pidx_ff] <= q_in;
            end else begin
               sum_ff <= sum_in;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_chan.opcode;
                  scale_ff <= 1'b0;
                  cnt_ff   <= '0;
                  pv_ff    <= 1'b0;
                  sum_ff   <= '0;
                  for (int i = 0; i < MAX_COEFS; i++) begin
                     neg_ff[i] <= req_coef[i][DW-1];
                     mag_ff[i] <= req_coef[i][DW-1] ? (DW'(0) - req_coef[i]) : req_coef[i];
                     q_ff[i]   <= '0;
                  end
                  case (req_chan.opcode)
                     hst_pkg::OP_SET: begin
                        lambda_ff <= req_chan.lambda_value;
                        armed_ff  <= (req_chan.lambda_value == '0);
                        state_ff  <= S_DONE;
                     end
                     hst_pkg::OP_MEASURE: begin
                        state_ff <= armed_ff ? S_MUL : S_DONE;
                     end
                     hst_pkg::OP_THRESHOLD: begin
                        state_ff <= S_MUL;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_MUL: begin
               prod_ff <= prod_in;
               pidx_ff <= cnt_ff;
               pv_ff   <= 1'b1;
               if (cnt_ff == last_idx) begin
                  state_ff <= S_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               pv_ff    <= 1'b0;
               state_ff <= scale_ff ? S_DONE : S_ROOT_GO;
            end
            S_ROOT_GO: begin
               if (sum_ff[SMW-1]) begin
                  norm_ff  <= 33'h1_0000_0000;
                  state_ff <= S_CMP;
               end else begin
                  cmd_ff.go <= 1'b1;
                  cmd_ff.op <= hst_pkg::UNIT_ROOT;
                  state_ff  <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (unit_stat.done) begin
                  norm_ff  <= {1'b0, unit_result};
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (op_ff == hst_pkg::OP_MEASURE) begin
                  if (norm_gt) begin
                     lambda_ff <= norm_ff;
                  end
                  state_ff <= S_DONE;
               end else begin
                  armed_ff <= 1'b0;
                  if (norm_gt) begin
                     cmd_ff.go <= 1'b1;
                     cmd_ff.op <= hst_pkg::UNIT_DIV;
                     state_ff  <= S_DIV;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DIV: begin
               if (unit_stat.done) begin
                  f_ff     <= f_in;
                  scale_ff <= 1'b1;
                  cnt_ff   <= '0;
                  pv_ff    <= 1'b0;
                  state_ff <= S_MUL;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  for (int i = 0; i < NF; i++) begin
                     rsp_coef_ff[i] <= q_ext[i];
                  end
                  rsp_lambda_ff <= lambda_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign csr_chan.ready      = 1'b1;
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_coef_0 = rsp_coef_ff[0];
   assign rsp_chan.out_coef_1 = rsp_coef_ff[1];
   assign rsp_chan.out_coef_2 = rsp_coef_ff[2];
   assign rsp_chan.out_coef_3 = rsp_coef_ff[3];
   assign rsp_chan.lambda_now = rsp_lambda_ff;

`ifndef SYNTHESIS
   a_lambda_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(lambda_ff)) |->
         ($past(state_ff) == S_IDLE || $past(state_ff) == S_CMP))
      else $error("lambda changed outside set or compare");

   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> (state_ff == S_ROOT || state_ff == S_DIV))
      else $error("root/divide result with no waiting state");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> norm_gt)
      else $error("divide running with norm not above lambda");

   a_disarm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && op_ff == hst_pkg::OP_THRESHOLD) |=> !armed_ff)
      else $error("threshold request left search armed");

   a_scale_factor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && scale_ff) |-> (f_ff != '0))
      else $error("zero scale factor");
`endif

endmodule

// ===== tb/hypercomplex_soft_threshold_tb.sv =====
// Self-checking testbench for hypercomplex_soft_threshold: drives set, measure, threshold and
// unused-opcode requests over all alg_dims settings and checks every response field.
// Depends on hst_pkg, hst_channels and the RTL top level.
module hypercomplex_soft_threshold_tb;

   localparam logic [hst_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned COEF_LIMIT   = 4;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned MAX_SHOWN    = 10;

   typedef logic [hst_pkg::OP_W-1:0] opcode_type;

   typedef struct packed {
      logic [hst_pkg::OP_W-1:0]                              opcode;
      logic [hst_pkg::NUM_FIELDS-1:0][hst_pkg::COEF_W-1:0]   coef;
      logic [hst_pkg::LAMBDA_W-1:0]                          lambda_value;
   } hst_request_type;

   typedef struct packed {
      logic [hst_pkg::NUM_FIELDS-1:0][hst_pkg::COEF_W-1:0]   coef;
      logic [hst_pkg::LAMBDA_W-1:0]                          lambda_now;
   } hst_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_MOSTLY,
      RX_HALF,
      RX_SPARSE
   } rx_mode_type;

   logic clock;
   logic reset;

   hst_req_if req_bus();
   hst_rsp_if rsp_bus();
   hst_csr_if csr_bus();

   hypercomplex_soft_threshold #(
      .MAX_COEFS (COEF_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_bus.sink),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // predictor state
   logic [hst_pkg::LAMBDA_W-1:0] lam_level;
   logic                         search_armed;
   logic [hst_pkg::DIMS_W-1:0]   dims_cfg;

   hst_result_type shrunk_q[$];
   hst_result_type got_rsp;
   hst_result_type want_rsp;

   int unsigned mismatches;
   int unsigned checked;
   int unsigned nonzero_shrunk;
   int unsigned total_sent;
   int unsigned sent_by_op [4];
   int unsigned burst_left;
   bit          steady_send;
   int unsigned idle_cycles;
   int unsigned hold_asked;
   int unsigned hold_taken;
   int unsigned hold_left;
   int unsigned mode_left;
   rx_mode_type ready_mode;

   always #5 clock = ~clock;

   function automatic logic [hst_pkg::COEF_W-1:0] magnitude(
         input logic [hst_pkg::COEF_W-1:0] c);
      return c[hst_pkg::COEF_W-1] ? (~c + 1'b1) : c;
   endfunction

   // floor(sqrt(sum of squares)), exact
   function automatic logic [hst_pkg::NORM_W-1:0] euclid_norm(input hst_request_type rq,
                                                              input int unsigned n);
      logic [67:0] sum;
      logic [67:0] root;
      logic [67:0] bitv;
      logic [hst_pkg::COEF_W-1:0] mag;
      sum = '0;
      for (int i = 0; i < n; i++) begin
         mag = magnitude(rq.coef[i]);
         sum += 68'(mag) * 68'(mag);
      end
      root = '0;
      bitv = 68'h1 << 66;
      while (bitv > sum)
         bitv >>= 2;
      while (bitv != 0) begin
         if (sum >= root + bitv) begin
            sum -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root[hst_pkg::NORM_W-1:0];
   endfunction

   function automatic hst_result_type soft_threshold(input hst_request_type rq);
      hst_result_type             res;
      int unsigned                n;
      logic [hst_pkg::NORM_W-1:0] nm;
      logic [65:0]                ratio;
      logic [32:0]                factor;
      logic [64:0]                scaled;
      res = '0;
      n = 1 << ((dims_cfg > 2) ? 2 : dims_cfg);
      if (n > COEF_LIMIT)
         n = COEF_LIMIT;
      case (rq.opcode)
         hst_pkg::OP_SET: begin
            lam_level = rq.lambda_value;
            search_armed = (rq.lambda_value == '0);
         end
         hst_pkg::OP_MEASURE: begin
            if (search_armed) begin
               nm = euclid_norm(rq, n);
               if (nm > lam_level)
                  lam_level = nm;
            end
         end
         hst_pkg::OP_THRESHOLD: begin
            nm = euclid_norm(rq, n);
            if (nm > lam_level) begin
               ratio = {1'b0, lam_level, 32'd0} / 66'(nm);
               factor = 33'h1_0000_0000 - ratio[32:0];
               for (int i = 0; i < n; i++) begin
                  // round half away from zero on the magnitude
                  scaled = (65'(magnitude(rq.coef[i])) * 65'(factor) + 65'h0_8000_0000) >> 32;
                  res.coef[i] = rq.coef[i][hst_pkg::COEF_W-1] ? -scaled[hst_pkg::COEF_W-1:0]
                                                              : scaled[hst_pkg::COEF_W-1:0];
               end
            end
            search_armed = 1'b0;
         end
         default: ;
      endcase
      res.lambda_now = lam_level;
      return res;
   endfunction

   function automatic hst_request_type mk_req(input logic [hst_pkg::OP_W-1:0] op,
                                              input logic [hst_pkg::COEF_W-1:0] c0, c1, c2, c3,
                                              input logic [hst_pkg::LAMBDA_W-1:0] lam);
      hst_request_type rq;
      rq.opcode = op;
      rq.coef[0] = c0;
      rq.coef[1] = c1;
      rq.coef[2] = c2;
      rq.coef[3] = c3;
      rq.lambda_value = lam;
      return rq;
   endfunction

   function automatic logic [hst_pkg::COEF_W-1:0] rand_coef(input int unsigned shift);
      logic [hst_pkg::COEF_W-1:0] mag;
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom();
         3: return 32'($urandom_range(0, 2) - 1);
         default: begin
            mag = $urandom() >> shift;
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [hst_pkg::LAMBDA_W-1:0] rand_lambda(input int unsigned shift);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {1'($urandom_range(0, 1)), 32'($urandom())};
         default: return 33'($urandom() >> shift) << $urandom_range(0, 1);
      endcase
   endfunction

   function automatic hst_request_type rand_req(input logic [hst_pkg::OP_W-1:0] op,
                                                input int unsigned shift);
      return mk_req(op, rand_coef(shift), rand_coef(shift), rand_coef(shift),
                    rand_coef(shift), rand_lambda(shift));
   endfunction

   task automatic send_req(input hst_request_type rq);
      if (!steady_send && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= rq.opcode;
      req_bus.coef_0       <= rq.coef[0];
      req_bus.coef_1       <= rq.coef[1];
      req_bus.coef_2       <= rq.coef[2];
      req_bus.coef_3       <= rq.coef[3];
      req_bus.lambda_value <= rq.lambda_value;
      do @(posedge clock); while (!req_bus.ready);
      shrunk_q.push_back(soft_threshold(rq));
      sent_by_op[rq.opcode]++;
      total_sent++;
   endtask

   task automatic idle_req();
      req_bus.valid <= 1'b0;
      burst_left = 0;
   endtask

   // only while nothing is outstanding
   task automatic write_alg_dims(input logic [hst_pkg::DIMS_W-1:0] dims);
      idle_req();
      while (shrunk_q.size() != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= dims;
      do @(posedge clock); while (!csr_bus.ready);
      dims_cfg = dims;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_random_items(input int unsigned target);
      int unsigned start;
      int unsigned shift;
      start = total_sent;
      while (total_sent - start < target) begin
         shift = $urandom_range(0, 24);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // arm, search for the max norm, then shrink with it
               send_req(mk_req(hst_pkg::OP_SET, $urandom(), $urandom(), $urandom(),
                               $urandom(), '0));
               repeat ($urandom_range(1, 6)) send_req(rand_req(hst_pkg::OP_MEASURE, shift));
               repeat ($urandom_range(1, 5)) send_req(rand_req(hst_pkg::OP_THRESHOLD, shift));
            end
            5, 6, 7: begin
               send_req(mk_req(hst_pkg::OP_SET, $urandom(), $urandom(), $urandom(),
                               $urandom(), rand_lambda(shift)));
               repeat ($urandom_range(1, 6))
                  send_req(rand_req($urandom_range(0, 4) == 0 ? hst_pkg::OP_MEASURE
                                                              : hst_pkg::OP_THRESHOLD,
                                    shift));
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  send_req(rand_req(opcode_type'($urandom_range(0, 3)),
                                    $urandom_range(0, 31)));
            end
         endcase
      end
   endtask

   task automatic test_directed_corners();
      steady_send = 1'b0;
      // reset state: armed, lambda 0, two coefficients
      send_req(mk_req(hst_pkg::OP_MEASURE, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678,
                      32'h8765_4321, '0));
      send_req(mk_req(hst_pkg::OP_MEASURE, 32'h0001_0000, 32'h0001_0000, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h0006_0000, 32'hFFF8_0000, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, '1));
      send_req(mk_req(hst_pkg::OP_MEASURE, 32'h0064_0000, 0, 0, 0, '0));
      send_req(mk_req(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, '1));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h0001_0000, 32'h0001_0000, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, '1));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h8000_0000, 32'h8000_0000, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, 33'd1));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, '0));

      write_alg_dims(2'd2);
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_MEASURE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, '0));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, '0));
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, 33'd1));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, '0));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0001, '0));

      write_alg_dims(2'd0);
      send_req(mk_req(hst_pkg::OP_SET, 0, 0, 0, 0, '0));
      send_req(mk_req(hst_pkg::OP_MEASURE, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '0));
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'hFFF8_8000, 32'h7FFF_FFFF, 1, 1, '0));

      // dims 3 behaves as 2
      write_alg_dims(2'd3);
      send_req(mk_req(hst_pkg::OP_THRESHOLD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '0));
      send_req(mk_req(OP_UNUSED, 0, 0, 0, 0, '0));
   endtask

   task automatic test_random_mix();
      logic [hst_pkg::DIMS_W-1:0] order [6];
      order = '{2'd2, 2'd0, 2'd3, 2'd1, 2'($urandom_range(0, 3)), 2'd2};
      foreach (order[i]) begin
         write_alg_dims(order[i]);
         steady_send = ($urandom_range(0, 2) == 0);
         run_random_items(290);
      end
   endtask

   task automatic test_output_stall();
      idle_req();
      while (shrunk_q.size() != 0) @(posedge clock);
      steady_send = 1'b1;
      hold_asked++;
      run_random_items(40);
      steady_send = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input hst_result_type want,
                                  input hst_result_type got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("%0s: expected %h %h %h %h lambda %h, got %h %h %h %h lambda %h", what,
                  want.coef[0], want.coef[1], want.coef[2], want.coef[3], want.lambda_now,
                  got.coef[0], got.coef[1], got.coef[2], got.coef[3], got.lambda_now);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_rsp.coef[0]    = rsp_bus.out_coef_0;
         got_rsp.coef[1]    = rsp_bus.out_coef_1;
         got_rsp.coef[2]    = rsp_bus.out_coef_2;
         got_rsp.coef[3]    = rsp_bus.out_coef_3;
         got_rsp.lambda_now = rsp_bus.lambda_now;
         if (shrunk_q.size() == 0) begin
            report_mismatch("unexpected response", '0, got_rsp);
         end else begin
            want_rsp = shrunk_q.pop_front();
            checked++;
            if (want_rsp.coef != '0)
               nonzero_shrunk++;
            if (got_rsp !== want_rsp)
               report_mismatch("response mismatch", want_rsp, got_rsp);
         end
      end
   end

   // response stalls; a requested long hold fills the block
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = $urandom_range(300, 500);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (ready_mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_HALF:   rsp_bus.ready <= ($urandom_range(0, 1) != 0);
               default:   rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake, %0d responses outstanding",
                  idle_cycles, shrunk_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.coef_0       = '0;
      req_bus.coef_1       = '0;
      req_bus.coef_2       = '0;
      req_bus.coef_3       = '0;
      req_bus.lambda_value = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;
      lam_level    = '0;
      search_armed = 1'b1;
      dims_cfg     = hst_pkg::ALG_DIMS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_mix();
      test_output_stall();

      idle_req();
      while (shrunk_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d set, %0d measure, %0d threshold, %0d ignored-opcode requests",
               sent_by_op[hst_pkg::OP_SET], sent_by_op[hst_pkg::OP_MEASURE],
               sent_by_op[hst_pkg::OP_THRESHOLD], sent_by_op[OP_UNUSED]);
      $display("alg_dims 0..3 exercised; %0d responses checked, %0d shrunk nonzero, %0d bad",
               checked, nonzero_shrunk, mismatches);
      if (mismatches == 0 && shrunk_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hst_pkg.sv
rtl/hst_channels.sv
rtl/hst_root_div.sv
rtl/hypercomplex_soft_threshold.sv
tb/hypercomplex_soft_threshold_tb.sv
